// File: design/smoa_pkg.sv
// ----------------------------------------------------------------------------
// smoa_pkg: shared definitions for the scalar modulo-order arithmetic unit
// Holds the group order, the inversion exponent, operation codes and the
// sequencer state type.
// ----------------------------------------------------------------------------
package smoa_pkg;

    localparam int ORDER_BITS  = 253;
    localparam int LIMB_W      = 64;
    localparam int TOP_LIMB_W  = ORDER_BITS - 3 * LIMB_W;
    localparam int IDX_W       = 8;

    typedef logic [ORDER_BITS-1:0] residue_t;

    localparam residue_t ORDER_Q =
        253'h1000000000000000000000000000000014def9dea2f79cd65812631a5cf5d3ed;
    localparam residue_t ORDER_Q_MINUS_2 =
        253'h1000000000000000000000000000000014def9dea2f79cd65812631a5cf5d3eb;

    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_SUB    = 3'd1;
    localparam logic [2:0] OP_MUL    = 3'd2;
    localparam logic [2:0] OP_HALVE  = 3'd3;
    localparam logic [2:0] OP_INVERT = 3'd4;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_REDA = 8'b0000_0010,
        ST_REDB = 8'b0000_0100,
        ST_OP   = 8'b0000_1000,
        ST_MDBL = 8'b0001_0000,
        ST_MADD = 8'b0010_0000,
        ST_MEND = 8'b0100_0000,
        ST_DONE = 8'b1000_0000
    } state_t;

endpackage

// File: design/scalar_mod_order_alu.sv
// ----------------------------------------------------------------------------
// scalar_mod_order_alu: add, subtract, multiply, halve and invert mod q
//
//   channel | direction | ports
//   s_      | in        | s_valid, s_ready, s_operation, s_a_limb*, s_b_limb*
//   m_      | out       | m_valid, m_ready, m_result_limb*, m_status
//
// Add, subtract and halve reduce both operands in turn, then compute the
// result and offer it from ST_DONE. Multiply runs bit serially through one
// shared modular adder, doubling for every multiplier bit and adding b where
// that bit is set. Invert is a chain of 326 such multiplies, 253 squarings and
// 73 multiplications by the operand. Reset is synchronous and returns to idle.
// The input is not ready while an item is in work or its result is held, so
// the next input beat comes at the earliest in the cycle after the result beat.
// ----------------------------------------------------------------------------
module scalar_mod_order_alu (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [2:0]                          s_operation,
    input  logic [smoa_pkg::LIMB_W-1:0]         s_a_limb0,
    input  logic [smoa_pkg::LIMB_W-1:0]         s_a_limb1,
    input  logic [smoa_pkg::LIMB_W-1:0]         s_a_limb2,
    input  logic [smoa_pkg::TOP_LIMB_W-1:0]     s_a_limb3,
    input  logic [smoa_pkg::LIMB_W-1:0]         s_b_limb0,
    input  logic [smoa_pkg::LIMB_W-1:0]         s_b_limb1,
    input  logic [smoa_pkg::LIMB_W-1:0]         s_b_limb2,
    input  logic [smoa_pkg::TOP_LIMB_W-1:0]     s_b_limb3,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [smoa_pkg::LIMB_W-1:0]         m_result_limb0,
    output logic [smoa_pkg::LIMB_W-1:0]         m_result_limb1,
    output logic [smoa_pkg::LIMB_W-1:0]         m_result_limb2,
    output logic [smoa_pkg::TOP_LIMB_W-1:0]     m_result_limb3,
    output logic                                m_status
);
    import smoa_pkg::*;

    state_t            state_reg, state_next;
    logic [2:0]        op_reg, op_next;
    residue_t          a_reg, a_next, b_reg, b_next;
    residue_t          mx_reg, mx_next, my_reg, my_next;
    residue_t          prod_reg, prod_next, res_reg, res_next;
    logic [IDX_W-1:0]  j_reg, j_next, e_reg, e_next;
    logic              sq_reg, sq_next, status_reg, status_next;

    residue_t          ux, uy, uz;
    logic              usub;
    logic [ORDER_BITS:0] half_sum;

    smoa_modadd u_modadd (.x(ux), .y(uy), .sub(usub), .z(uz));

    assign half_sum = {1'b0, a_reg} + (a_reg[0] ? {1'b0, ORDER_Q} : '0);

    always_comb begin
        ux   = a_reg;
        uy   = b_reg;
        usub = 1'b0;
        case (state_reg)
            ST_REDA: uy = '0;
            ST_REDB: begin
                ux = b_reg;
                uy = '0;
            end
            ST_OP:   usub = (op_reg == OP_SUB);
            ST_MDBL: begin
                ux = prod_reg;
                uy = prod_reg;
            end
            ST_MADD: begin
                ux = prod_reg;
                uy = my_reg;
            end
            default: ;
        endcase
    end

    always_comb begin
        state_next  = state_reg;
        op_next     = op_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        mx_next     = mx_reg;
        my_next     = my_reg;
        prod_next   = prod_reg;
        res_next    = res_reg;
        j_next      = j_reg;
        e_next      = e_reg;
        sq_next     = sq_reg;
        status_next = status_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next    = s_operation;
                    a_next     = {s_a_limb3, s_a_limb2, s_a_limb1, s_a_limb0};
                    b_next     = {s_b_limb3, s_b_limb2, s_b_limb1, s_b_limb0};
                    state_next = ST_REDA;
                end
            end
            ST_REDA: begin
                a_next     = uz;
                state_next = ST_REDB;
            end
            ST_REDB: begin
                b_next     = uz;
                state_next = ST_OP;
            end
            ST_OP: begin
                status_next = 1'b0;
                res_next    = '0;
                state_next  = ST_DONE;
                prod_next   = '0;
                j_next      = IDX_W'(ORDER_BITS - 1);
                case (op_reg)
                    OP_ADD, OP_SUB: res_next = uz;
                    OP_HALVE:       res_next = half_sum[ORDER_BITS:1];
                    OP_MUL: begin
                        mx_next    = a_reg;
                        my_next    = b_reg;
                        state_next = ST_MDBL;
                    end
                    OP_INVERT: begin
                        if (a_reg == '0) begin
                            status_next = 1'b1;
                        end else begin
                            mx_next    = residue_t'(1);
                            my_next    = residue_t'(1);
                            e_next     = IDX_W'(ORDER_BITS - 1);
                            sq_next    = 1'b1;
                            state_next = ST_MDBL;
                        end
                    end
                    default: ;
                endcase
            end
            ST_MDBL, ST_MADD: begin
                prod_next = uz;
                if (state_reg == ST_MDBL && mx_reg[j_reg]) begin
                    state_next = ST_MADD;
                end else if (j_reg == '0) begin
                    state_next = ST_MEND;
                end else begin
                    j_next     = j_reg - 1'b1;
                    state_next = ST_MDBL;
                end
            end
            ST_MEND: begin
                j_next     = IDX_W'(ORDER_BITS - 1);
                state_next = ST_MDBL;
                if (op_reg != OP_INVERT) begin
                    res_next   = prod_reg;
                    state_next = ST_DONE;
                end else if (sq_reg && ORDER_Q_MINUS_2[e_reg]) begin
                    mx_next = prod_reg;
                    my_next = a_reg;
                    sq_next = 1'b0;
                end else if (e_reg == '0) begin
                    res_next   = prod_reg;
                    state_next = ST_DONE;
                end else begin
                    e_next  = e_reg - 1'b1;
                    sq_next = 1'b1;
                    mx_next = prod_reg;
                    my_next = prod_reg;
                end
                prod_next = '0;
            end
            ST_DONE: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            status_reg <= 1'b0;
            sq_reg     <= 1'b0;
        end else begin
            state_reg  <= state_next;
            status_reg <= status_next;
            sq_reg     <= sq_next;
        end
        op_reg   <= op_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        mx_reg   <= mx_next;
        my_reg   <= my_next;
        prod_reg <= prod_next;
        res_reg  <= res_next;
        j_reg    <= j_next;
        e_reg    <= e_next;
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = (state_reg == ST_DONE);
    assign m_result_limb0 = res_reg[LIMB_W-1:0];
    assign m_result_limb1 = res_reg[2*LIMB_W-1:LIMB_W];
    assign m_result_limb2 = res_reg[3*LIMB_W-1:2*LIMB_W];
    assign m_result_limb3 = res_reg[ORDER_BITS-1:3*LIMB_W];
    assign m_status       = status_reg;

    a_busy_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(m_valid && s_ready))
        else $error("Input ready while a result is held.");

    a_accept_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_REDA))
        else $error("Accepted beat did not start operand reduction.");

    a_status_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status) |-> (res_reg == '0 && op_reg == OP_INVERT))
        else $error("Zero inversion status with nonzero result.");

    a_result_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (res_reg < ORDER_Q))
        else $error("Result not reduced below the group order.");

endmodule

// File: design/smoa_modadd.sv
// ----------------------------------------------------------------------------
// smoa_modadd: shared modular adder and subtractor
// Returns x + y or x - y reduced modulo the group order for inputs below q.
// ----------------------------------------------------------------------------
module smoa_modadd (
    input  smoa_pkg::residue_t x,
    input  smoa_pkg::residue_t y,
    input  logic               sub,
    output smoa_pkg::residue_t z
);
    import smoa_pkg::*;

    logic [ORDER_BITS:0] sum;
    logic [ORDER_BITS:0] corr;

    always_comb begin
        if (sub) begin
            sum  = {1'b0, x} - {1'b0, y};
            corr = sum + {1'b0, ORDER_Q};
            z    = sum[ORDER_BITS] ? corr[ORDER_BITS-1:0] : sum[ORDER_BITS-1:0];
        end else begin
            sum  = {1'b0, x} + {1'b0, y};
            corr = sum - {1'b0, ORDER_Q};
            z    = (sum >= {1'b0, ORDER_Q}) ? corr[ORDER_BITS-1:0]
                                            : sum[ORDER_BITS-1:0];
        end
    end

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the scalar modulo-order arithmetic unit
// A short table of directed beats covers the operand extremes, every
// operation, operands at or above the order, inversion of zero and the
// unused operation codes. A long random run follows. Every result is checked
// against the table's value or modular arithmetic done here on wide vectors. Both
// channels idle at random, and one long receiver hold-off backs the unit up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import smoa_pkg::*;

    localparam int  RANDOM_BEATS = 1300;
    localparam int  HOLD_CYCLES  = 3000;
    localparam longint CYCLE_LIMIT = 20_000_000;

    typedef struct {
        residue_t value;
        logic     status;
    } outcome_t;

    typedef struct {
        logic [2:0] op;
        residue_t   a;
        residue_t   b;
        logic       typed;
        residue_t   value;
        logic       status;
    } vector_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [2:0]            s_operation = '0;
    logic [LIMB_W-1:0]     s_a_limb0 = '0, s_a_limb1 = '0, s_a_limb2 = '0;
    logic [TOP_LIMB_W-1:0] s_a_limb3 = '0;
    logic [LIMB_W-1:0]     s_b_limb0 = '0, s_b_limb1 = '0, s_b_limb2 = '0;
    logic [TOP_LIMB_W-1:0] s_b_limb3 = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [LIMB_W-1:0]     m_result_limb0, m_result_limb1, m_result_limb2;
    logic [TOP_LIMB_W-1:0] m_result_limb3;
    logic                  m_status;

    outcome_t pending_results[$];
    int       mismatches = 0;
    int       op_counts[8];
    int       zero_invert_beats = 0;
    longint   cycle_count = 0;
    bit       calm = 1'b0;
    bit       hold_request = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    scalar_mod_order_alu dut (.*);

    function automatic residue_t reduce_order(residue_t x);
        return (x >= ORDER_Q) ? x - ORDER_Q : x;
    endfunction

    function automatic residue_t mul_order(residue_t x, residue_t y);
        logic [2*ORDER_BITS-1:0] product;
        product = {{ORDER_BITS{1'b0}}, x} * {{ORDER_BITS{1'b0}}, y};
        return residue_t'(product % {{ORDER_BITS{1'b0}}, ORDER_Q});
    endfunction

    function automatic outcome_t predict_scalar_op(logic [2:0] op, residue_t a_in,
                                                   residue_t b_in);
        outcome_t res;
        residue_t a, b, acc;
        logic [ORDER_BITS:0] wide;
        a = reduce_order(a_in);
        b = reduce_order(b_in);
        res.value = '0;
        res.status = 1'b0;
        case (op)
            OP_ADD: begin
                wide = {1'b0, a} + {1'b0, b};
                res.value = (wide >= {1'b0, ORDER_Q}) ? residue_t'(wide - ORDER_Q)
                                                     : residue_t'(wide);
            end
            OP_SUB: res.value = (a >= b) ? a - b : a + ORDER_Q - b;
            OP_MUL: res.value = mul_order(a, b);
            OP_HALVE: begin
                wide = a[0] ? {1'b0, a} + {1'b0, ORDER_Q} : {1'b0, a};
                res.value = residue_t'(wide >> 1);
            end
            OP_INVERT: begin
                if (a == '0) begin
                    res.status = 1'b1;
                end else begin
                    acc = residue_t'(1);
                    for (int i = ORDER_BITS - 1; i >= 0; i--) begin
                        acc = mul_order(acc, acc);
                        if (ORDER_Q_MINUS_2[i]) acc = mul_order(acc, a);
                    end
                    res.value = acc;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic residue_t random_operand();
        residue_t x;
        for (int i = 0; i < 7; i++) x[i*32 +: 32] = $urandom;
        x[252:224] = 29'($urandom);
        case ($urandom_range(0, 7))
            0:       return residue_t'($urandom_range(0, 3));
            1:       return ORDER_Q - residue_t'($urandom_range(1, 4));
            2:       return ORDER_Q + residue_t'($urandom_range(0, 4));
            3:       return '1;
            4, 5:    return reduce_order(x);
            default: return x;
        endcase
    endfunction

    function automatic logic [2:0] random_op();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 30) return OP_ADD;
        if (pick < 60) return OP_SUB;
        if (pick < 80) return OP_HALVE;
        if (pick < 97) return OP_MUL;
        return 3'($urandom_range(5, 7));
    endfunction

    task automatic send_beat(logic [2:0] op, residue_t a, residue_t b, logic typed,
                             residue_t value, logic status);
        outcome_t res;
        s_operation <= op;
        s_a_limb0 <= a[63:0];
        s_a_limb1 <= a[127:64];
        s_a_limb2 <= a[191:128];
        s_a_limb3 <= a[252:192];
        s_b_limb0 <= b[63:0];
        s_b_limb1 <= b[127:64];
        s_b_limb2 <= b[191:128];
        s_b_limb3 <= b[252:192];
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        if (typed) begin
            res.value = value;
            res.status = status;
        end else begin
            res = predict_scalar_op(op, a, b);
        end
        pending_results.push_back(res);
        op_counts[op]++;
        if (op == OP_INVERT && reduce_order(a) == '0) zero_invert_beats++;
        if (!calm && $urandom_range(0, 99) < 18) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic check_field(string name, residue_t want, residue_t got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        outcome_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: result beat with no expected result, actual %h %h %h %h %b",
                         $time, m_result_limb3, m_result_limb2, m_result_limb1,
                         m_result_limb0, m_status);
            end else begin
                want = pending_results.pop_front();
                check_field("result_limb0", residue_t'(want.value[63:0]),
                            residue_t'(m_result_limb0));
                check_field("result_limb1", residue_t'(want.value[127:64]),
                            residue_t'(m_result_limb1));
                check_field("result_limb2", residue_t'(want.value[191:128]),
                            residue_t'(m_result_limb2));
                check_field("result_limb3", residue_t'(want.value[252:192]),
                            residue_t'(m_result_limb3));
                check_field("status", residue_t'(want.status), residue_t'(m_status));
            end
        end
    end

    initial begin
        bit hold_done;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request && !hold_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end
            m_ready <= calm || ($urandom_range(0, 99) >= 18);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    initial begin
        vector_t  vectors[$];
        residue_t q_less_1;
        residue_t one;
        residue_t two;
        q_less_1 = ORDER_Q - 1;
        one = residue_t'(1);
        two = residue_t'(2);
        vectors = '{
            '{OP_ADD,    '0,        '0,        1'b1, '0,          1'b0},
            '{OP_ADD,    q_less_1,  one,       1'b1, '0,          1'b0},
            '{OP_ADD,    '1,        '1,        1'b0, '0,          1'b0},
            '{OP_ADD,    ORDER_Q,   q_less_1,  1'b1, q_less_1,    1'b0},
            '{OP_SUB,    '0,        one,       1'b1, q_less_1,    1'b0},
            '{OP_SUB,    q_less_1,  q_less_1,  1'b1, '0,          1'b0},
            '{OP_SUB,    '1,        ORDER_Q,   1'b0, '0,          1'b0},
            '{OP_MUL,    q_less_1,  q_less_1,  1'b1, one,         1'b0},
            '{OP_MUL,    '1,        '1,        1'b0, '0,          1'b0},
            '{OP_MUL,    '0,        '1,        1'b1, '0,          1'b0},
            '{OP_HALVE,  one,       '1,        1'b0, '0,          1'b0},
            '{OP_HALVE,  '1,        '0,        1'b0, '0,          1'b0},
            '{OP_HALVE,  two,       '0,        1'b1, one,         1'b0},
            '{OP_INVERT, '0,        '1,        1'b1, '0,          1'b1},
            '{OP_INVERT, ORDER_Q,   '0,        1'b1, '0,          1'b1},
            '{OP_INVERT, one,       '1,        1'b1, one,         1'b0},
            '{OP_INVERT, 253'h0f3a_5c71_9e2d_4b86_c0a1_77e3_2d95_b4c8_6a1f_e0d3_5b27_9c48_e61a,
                                    '0,        1'b0, '0,          1'b0},
            '{3'd5,      '1,        '1,        1'b1, '0,          1'b0},
            '{3'd6,      q_less_1,  one,       1'b1, '0,          1'b0},
            '{3'd7,      one,       q_less_1,  1'b1, '0,          1'b0}
        };
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (vectors[i])
            send_beat(vectors[i].op, vectors[i].a, vectors[i].b, vectors[i].typed,
                      vectors[i].value, vectors[i].status);
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            calm = (n >= 600 && n < 800);
            if (n == 300) hold_request = 1'b1;
            send_beat(random_op(), random_operand(), random_operand(), 1'b0, '0, 1'b0);
        end
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        $display("Covered %0d add, %0d subtract, %0d multiply, %0d halve, %0d invert",
                 op_counts[OP_ADD], op_counts[OP_SUB], op_counts[OP_MUL],
                 op_counts[OP_HALVE], op_counts[OP_INVERT]);
        $display("and %0d unused-code beats; %0d inversions of zero, one long stall.",
                 op_counts[5] + op_counts[6] + op_counts[7], zero_invert_beats);
        if (mismatches == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

// File: scalar_mod_order_alu.f
design/smoa_pkg.sv
design/smoa_modadd.sv
design/scalar_mod_order_alu.sv
verif/tb.sv
